/* rtl/dtts_pkg.sv */
package dtts_pkg;

  localparam int NUMBER_BITS_DEF = 31;
  localparam int CHAR_BITS       = 8;
  localparam int TOTAL_BITS      = 43;

  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_BITS-1:0] CH_LC_H  = 8'h68;
  localparam logic [CHAR_BITS-1:0] CH_LC_M  = 8'h6D;
  localparam logic [CHAR_BITS-1:0] CH_LC_S  = 8'h73;

  // grammar position: N = number, C = colon, H/M = unit letter seen
  typedef enum logic [3:0] {
    G_START,
    G_N1,
    G_C1,
    G_C1N,
    G_C2,
    G_C2N,
    G_H,
    G_HN,
    G_HNM,
    G_HNMN,
    G_M,
    G_MN,
    G_SEND,
    G_ERR
  } gstate_t;

endpackage

/* rtl/dtts_if.sv */
interface dtts_in_if import dtts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;
  logic                 last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dtts_out_if import dtts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TOTAL_BITS-1:0] total_seconds;
  logic                  matched;

  modport source (output valid, output total_seconds, output matched, input ready);
  modport sink   (input valid, input total_seconds, input matched, output ready);
endinterface

/* rtl/dtts_parser.sv */
module dtts_parser import dtts_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [CHAR_BITS-1:0]   char_code,
  input  logic                   last_char,
  output logic [NUMBER_BITS-1:0] fin_hours,
  output logic [NUMBER_BITS-1:0] fin_minutes,
  output logic [NUMBER_BITS-1:0] fin_seconds,
  output logic                   fin_ok
);

  localparam int WIDE_BITS = NUMBER_BITS + 4;

  gstate_t                  state_r, state_nxt;
  logic [NUMBER_BITS-1:0]   acc_r, acc_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [NUMBER_BITS-1:0]   hours_r, hours_nxt;
  logic [NUMBER_BITS-1:0]   minutes_r, minutes_nxt;
  logic [NUMBER_BITS-1:0]   seconds_r, seconds_nxt;

  logic                     is_ws, is_digit, is_sep;
  logic                     num_start, num_cont;
  logic [NUMBER_BITS-1:0]   base_acc;
  logic                     base_ovf;
  logic [WIDE_BITS-1:0]     wide;
  logic                     wide_ovf;
  logic [NUMBER_BITS-1:0]   cur_val;
  logic [NUMBER_BITS-1:0]   end_val;

  assign is_ws    = char_code inside {CH_SPACE, [CH_TAB:CH_CR]};
  assign is_digit = char_code inside {[CH_ZERO:CH_NINE]};
  assign is_sep   = char_code inside {CH_COLON, CH_LC_H, CH_LC_M, CH_LC_S};

  // accumulate: acc*10 + digit, widened to catch overflow
  assign base_acc = num_start ? '0 : acc_r;
  assign base_ovf = num_start ? 1'b0 : ovf_r;
  assign wide     = (WIDE_BITS'(base_acc) << 3) + (WIDE_BITS'(base_acc) << 1)
                  + WIDE_BITS'(char_code[3:0]);
  assign wide_ovf = wide[WIDE_BITS-1:NUMBER_BITS] != '0;
  assign cur_val  = ovf_r ? '0 : acc_r;

  always_comb begin
    num_start = 1'b0;
    num_cont  = 1'b0;
    case (state_r)
      G_START, G_C1, G_C2, G_H, G_HNM, G_M: num_start = 1'b1;
      G_N1, G_C1N, G_C2N, G_HN, G_HNMN, G_MN: num_cont = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    hours_nxt   = hours_r;
    minutes_nxt = minutes_r;
    seconds_nxt = seconds_r;
    if (is_ws) begin
      state_nxt = state_r;
    end else if (is_digit) begin
      if (num_start || num_cont) begin
        case (state_r)
          G_START: state_nxt = G_N1;
          G_C1:    state_nxt = G_C1N;
          G_C2:    state_nxt = G_C2N;
          G_H:     state_nxt = G_HN;
          G_HNM:   state_nxt = G_HNMN;
          G_M:     state_nxt = G_MN;
          default: state_nxt = state_r;
        endcase
        if (base_ovf) begin
          acc_nxt = '0;
          ovf_nxt = 1'b1;
        end else if (wide_ovf) begin
          acc_nxt = '0;
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = wide[NUMBER_BITS-1:0];
          ovf_nxt = 1'b0;
        end
      end else begin
        state_nxt = G_ERR;
      end
    end else if (is_sep) begin
      state_nxt = G_ERR;
      case (state_r)
        G_N1: begin
          if (char_code == CH_COLON) begin
            minutes_nxt = cur_val;
            state_nxt   = G_C1;
          end else if (char_code == CH_LC_H) begin
            hours_nxt = cur_val;
            state_nxt = G_H;
          end else if (char_code == CH_LC_M) begin
            minutes_nxt = cur_val;
            state_nxt   = G_M;
          end else begin
            seconds_nxt = cur_val;
            state_nxt   = G_SEND;
          end
        end
        G_C1N: begin
          if (char_code == CH_COLON) begin
            hours_nxt   = minutes_r;
            minutes_nxt = cur_val;
            state_nxt   = G_C2;
          end
        end
        G_HN: begin
          if (char_code == CH_LC_M) begin
            minutes_nxt = cur_val;
            state_nxt   = G_HNM;
          end else if (char_code == CH_LC_S) begin
            seconds_nxt = cur_val;
            state_nxt   = G_SEND;
          end
        end
        G_HNMN, G_MN: begin
          if (char_code == CH_LC_S) begin
            seconds_nxt = cur_val;
            state_nxt   = G_SEND;
          end
        end
        default: state_nxt = G_ERR;
      endcase
    end else begin
      state_nxt = G_ERR;
    end
  end

  // close out the pending number at end of text
  assign end_val = ovf_nxt ? '0 : acc_nxt;

  always_comb begin
    fin_hours   = hours_nxt;
    fin_minutes = minutes_nxt;
    fin_seconds = seconds_nxt;
    fin_ok      = 1'b1;
    case (state_nxt)
      G_N1, G_HN:                  fin_minutes = end_val;
      G_C1N, G_C2N, G_HNMN, G_MN:  fin_seconds = end_val;
      G_H, G_HNM, G_M, G_SEND:     fin_ok = 1'b1;
      default:                     fin_ok = 1'b0;
    endcase
    if (!fin_ok) begin
      fin_hours   = '0;
      fin_minutes = '0;
      fin_seconds = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= G_START;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      hours_r   <= '0;
      minutes_r <= '0;
      seconds_r <= '0;
    end else if (step) begin
      if (last_char) begin
        // start over for the next string
        state_r   <= G_START;
        acc_r     <= '0;
        ovf_r     <= 1'b0;
        hours_r   <= '0;
        minutes_r <= '0;
        seconds_r <= '0;
      end else begin
        state_r   <= state_nxt;
        acc_r     <= acc_nxt;
        ovf_r     <= ovf_nxt;
        hours_r   <= hours_nxt;
        minutes_r <= minutes_nxt;
        seconds_r <= seconds_nxt;
      end
    end
  end

endmodule

/* rtl/dtts_total.sv */
module dtts_total import dtts_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   prod_en,
  input  logic                   sum_en,
  input  logic [NUMBER_BITS-1:0] hours,
  input  logic [NUMBER_BITS-1:0] minutes,
  input  logic [NUMBER_BITS-1:0] seconds,
  input  logic                   ok,
  output logic [TOTAL_BITS-1:0]  total_seconds,
  output logic                   matched
);

  logic [TOTAL_BITS-1:0]  hprod_r;
  logic [TOTAL_BITS-1:0]  mprod_r;
  logic [NUMBER_BITS-1:0] secs_r;
  logic                   ok_r;
  logic [TOTAL_BITS-1:0]  total_r;
  logic                   matched_r;

  // constant products first, then one three-way sum
  always_ff @(posedge clk) begin
    if (prod_en) begin
      hprod_r <= TOTAL_BITS'(hours) * TOTAL_BITS'(SECS_PER_HOUR);
      mprod_r <= TOTAL_BITS'(minutes) * TOTAL_BITS'(SECS_PER_MIN);
      secs_r  <= seconds;
      ok_r    <= ok;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      total_r   <= hprod_r + mprod_r + TOTAL_BITS'(secs_r);
      matched_r <= ok_r;
    end
  end

  assign total_seconds = total_r;
  assign matched       = matched_r;

endmodule

/* rtl/duration_text_to_seconds_core.sv */
// Channel  Dir  Word                              Meaning
// in_chan  in   char_code[7:0], last_char          one text character, last marks end
// out_chan out  total_seconds[42:0], matched       one word per string, at its last char
//
// One character is taken every cycle unless stalled as below; the grammar and digit
// accumulator advance in one step. Results pass the parse, products and sum registers.
// Synchronous active-low reset clears the grammar state and all valid flags.
// A stalled output only blocks the input when a last character must wait for a free slot;
// ordinary characters keep flowing into the parser.
module duration_text_to_seconds_core import dtts_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dtts_in_if.sink   in_chan,
  dtts_out_if.source out_chan
);

  logic                   a_valid_r;
  logic [CHAR_BITS-1:0]   a_char_r;
  logic                   a_last_r;
  logic                   c_valid_r;
  logic [NUMBER_BITS-1:0] c_hours_r, c_minutes_r, c_seconds_r;
  logic                   c_ok_r;
  logic                   d_valid_r;
  logic                   o_valid_r;

  logic                   o_free, d_free, c_free, a_go, a_free;
  logic [NUMBER_BITS-1:0] fin_hours, fin_minutes, fin_seconds;
  logic                   fin_ok;

  assign o_free = !o_valid_r || out_chan.ready;
  assign d_free = !d_valid_r || o_free;
  assign c_free = !c_valid_r || d_free;
  // a last character needs room in the finished-value stage
  assign a_go   = a_valid_r && (!a_last_r || c_free);
  assign a_free = !a_valid_r || a_go;

  assign in_chan.ready = a_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (a_free) a_valid_r <= in_chan.valid;
      if (c_free) c_valid_r <= a_go && a_last_r;
      if (d_free) d_valid_r <= c_valid_r;
      if (o_free) o_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_char_r <= in_chan.char_code;
      a_last_r <= in_chan.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free) begin
      c_hours_r   <= fin_hours;
      c_minutes_r <= fin_minutes;
      c_seconds_r <= fin_seconds;
      c_ok_r      <= fin_ok;
    end
  end

  dtts_parser #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (a_go),
    .char_code  (a_char_r),
    .last_char  (a_last_r),
    .fin_hours  (fin_hours),
    .fin_minutes(fin_minutes),
    .fin_seconds(fin_seconds),
    .fin_ok     (fin_ok)
  );

  dtts_total #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_total (
    .clk          (clk),
    .prod_en      (d_free),
    .sum_en       (o_free),
    .hours        (c_hours_r),
    .minutes      (c_minutes_r),
    .seconds      (c_seconds_r),
    .ok           (c_ok_r),
    .total_seconds(out_chan.total_seconds),
    .matched      (out_chan.matched)
  );

  assign out_chan.valid = o_valid_r;

endmodule

/* tb/duration_text_to_seconds_check.sv */
module duration_text_to_seconds_check import dtts_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  dtts_in_if   in_mon,
  dtts_out_if  out_mon,
  output int   fail_count,
  output int   open_totals
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] total_seconds;
    logic                  matched;
  } duration_t;

  localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;

  gstate_t                gram;
  logic [NUMBER_BITS-1:0] acc;
  logic                   acc_ovf;
  logic [NUMBER_BITS-1:0] hours;
  logic [NUMBER_BITS-1:0] mins;
  logic [NUMBER_BITS-1:0] secs;
  duration_t              due_totals[$];

  task automatic clear_parse();
    gram    = G_START;
    acc     = '0;
    acc_ovf = 1'b0;
    hours   = '0;
    mins    = '0;
    secs    = '0;
  endtask

  always @(posedge clk) begin : track
    logic [NUMBER_BITS+3:0] grown;
    logic [NUMBER_BITS-1:0] num;
    logic [CHAR_BITS-1:0]   c;
    gstate_t                nxt;
    logic                   hit;
    duration_t              want;
    duration_t              got;
    if (!rst_n) begin
      clear_parse();
      due_totals.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        c   = in_mon.char_code;
        num = acc_ovf ? '0 : acc;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          // whitespace leaves the parse untouched
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          case (gram)
            G_START: nxt = G_N1;
            G_C1:    nxt = G_C1N;
            G_C2:    nxt = G_C2N;
            G_H:     nxt = G_HN;
            G_HNM:   nxt = G_HNMN;
            G_M:     nxt = G_MN;
            G_N1, G_C1N, G_C2N, G_HN, G_HNMN, G_MN: nxt = gram;
            default: nxt = G_ERR;
          endcase
          // a fresh number starts from zero
          if (nxt != gram && nxt != G_ERR) begin
            acc     = '0;
            acc_ovf = 1'b0;
          end
          if (nxt != G_ERR && !acc_ovf) begin
            grown = {4'b0, acc} * 10 + (c - CH_ZERO);
            if (grown > {4'b0, NUM_MAX}) begin
              acc_ovf = 1'b1;
              acc     = '0;
            end else begin
              acc = grown[NUMBER_BITS-1:0];
            end
          end
          gram = nxt;
        end else if (c == CH_COLON || c == CH_LC_H || c == CH_LC_M || c == CH_LC_S) begin
          nxt = G_ERR;
          case (gram)
            G_N1: begin
              if (c == CH_COLON) begin
                mins = num;
                nxt  = G_C1;
              end else if (c == CH_LC_H) begin
                hours = num;
                nxt   = G_H;
              end else if (c == CH_LC_M) begin
                mins = num;
                nxt  = G_M;
              end else begin
                secs = num;
                nxt  = G_SEND;
              end
            end
            G_C1N: begin
              // second colon: the first number turns out to be hours
              if (c == CH_COLON) begin
                hours = mins;
                mins  = num;
                nxt   = G_C2;
              end
            end
            G_HN: begin
              if (c == CH_LC_M) begin
                mins = num;
                nxt  = G_HNM;
              end else if (c == CH_LC_S) begin
                secs = num;
                nxt  = G_SEND;
              end
            end
            G_HNMN, G_MN: begin
              if (c == CH_LC_S) begin
                secs = num;
                nxt  = G_SEND;
              end
            end
            default: ;
          endcase
          gram = nxt;
        end else begin
          gram = G_ERR;
        end

        if (in_mon.last_char) begin
          num = acc_ovf ? '0 : acc;
          hit = 1'b1;
          case (gram)
            G_N1, G_HN:                 mins = num;
            G_C1N, G_C2N, G_HNMN, G_MN: secs = num;
            G_H, G_HNM, G_M, G_SEND:    ;
            default:                    hit = 1'b0;
          endcase
          want.matched       = hit;
          want.total_seconds = hit ? (TOTAL_BITS'(hours) * TOTAL_BITS'(SECS_PER_HOUR)
                                      + TOTAL_BITS'(mins) * TOTAL_BITS'(SECS_PER_MIN)
                                      + TOTAL_BITS'(secs)) : '0;
          due_totals.push_back(want);
          clear_parse();
        end
      end

      if (out_mon.valid && out_mon.ready) begin
        got.total_seconds = out_mon.total_seconds;
        got.matched       = out_mon.matched;
        if (due_totals.size() == 0) begin
          $error("word with none expected: total_seconds %0d, matched %0b",
                 got.total_seconds, got.matched);
          fail_count++;
        end else begin
          want = due_totals.pop_front();
          if (got.total_seconds !== want.total_seconds) begin
            $error("total_seconds: expected %0d, got %0d",
                   want.total_seconds, got.total_seconds);
            fail_count++;
          end
          if (got.matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, got.matched);
            fail_count++;
          end
        end
      end
    end
    open_totals <= due_totals.size();
  end

endmodule

/* tb/duration_text_to_seconds_core_tb.sv */
module duration_text_to_seconds_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtts_pkg::*;

  localparam int TEXT_ITEMS = 1600;
  localparam int LONG_HOLD  = 400;

  logic                 clk;
  logic                 rst_n;
  int                   fail_count;
  int                   open_totals;
  int unsigned          chars_sent;
  bit                   hold_req;
  logic [CHAR_BITS-1:0] text[$];

  dtts_in_if  in_chan ();
  dtts_out_if out_chan ();

  duration_text_to_seconds_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  duration_text_to_seconds_check parse_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .fail_count  (fail_count),
    .open_totals (open_totals)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [CHAR_BITS-1:0] blank_char();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + CHAR_BITS'(r);
  endfunction

  // sprinkle whitespace now and then, it must be skipped anywhere
  function automatic void put(logic [CHAR_BITS-1:0] c);
    if ($urandom_range(0, 7) == 0) text.push_back(blank_char());
    text.push_back(c);
  endfunction

  function automatic logic [CHAR_BITS-1:0] any_char();
    string pool;
    pool = "0123456789:hms";
    case ($urandom_range(0, 3))
      0, 1:    return pool[$urandom_range(0, pool.len() - 1)];
      2:       return blank_char();
      default: return CHAR_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void put_number();
    string       limit_nums[4] = '{"2147483647", "2147483648", "4294967295",
                                   "0002147483647"};
    string       s;
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 19);
    if (kind >= 18) begin
      s = limit_nums[$urandom_range(0, 3)];
      for (int i = 0; i < s.len(); i++) put(s[i]);
    end else begin
      len = (kind < 12) ? $urandom_range(1, 2) :
            (kind < 16) ? $urandom_range(3, 5) : $urandom_range(9, 12);
      repeat (len) put(CH_ZERO + CHAR_BITS'($urandom_range(0, 9)));
    end
  endfunction

  function automatic void put_shape();
    int unsigned shape;
    logic [2:0]  units;
    shape = $urandom_range(0, 13);
    units = 3'(shape - 6);
    case (shape)
      0: put_number();
      1: begin
        put_number(); put(CH_COLON); put_number();
      end
      2: begin
        put_number(); put(CH_COLON); put_number(); put(CH_COLON); put_number();
      end
      3: begin
        put_number(); put(CH_LC_M); put_number();
      end
      4: begin
        put_number(); put(CH_LC_H);
      end
      5: begin
        put_number(); put(CH_LC_H); put_number();
      end
      6: begin
        put_number(); put(CH_LC_H); put_number(); put(CH_LC_M); put_number();
      end
      default: begin
        if (units[2]) begin
          put_number(); put(CH_LC_H);
        end
        if (units[1]) begin
          put_number(); put(CH_LC_M);
        end
        if (units[0]) begin
          put_number(); put(CH_LC_S);
        end
      end
    endcase
  endfunction

  // mostly well-formed text, some of it damaged, the rest noise
  function automatic void make_text();
    int unsigned r;
    int unsigned pos;
    text.delete();
    r = $urandom_range(0, 99);
    if (r < 75) begin
      put_shape();
    end else if (r < 90) begin
      put_shape();
      pos = $urandom_range(0, text.size() - 1);
      case ($urandom_range(0, 2))
        0:       text[pos] = any_char();
        1:       text.delete(pos);
        default: text.insert(pos, any_char());
      endcase
    end else begin
      repeat ($urandom_range(1, 6)) text.push_back(any_char());
    end
    if (text.size() == 0 || $urandom_range(0, 9) == 0) text.push_back(blank_char());
  endfunction

  task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic fin, input bit no_idle);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.char_code <= c;
    in_chan.last_char <= fin;
    do @(posedge clk); while (!in_chan.ready);
    if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) chars_sent++;
  endtask

  task automatic send_text(input bit no_idle);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1, no_idle);
  endtask

  initial begin : result_side
    int unsigned gap;
    int unsigned served;
    bit          held;
    out_chan.ready <= 1'b0;
    served = 0;
    held   = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = ((served / 24) % 3 == 0) ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      served++;
    end
  end

  initial begin : text_side
    string       directed[5] = '{" ", "1:2:3", "3m9", "1h2m3s", "2147483648"};
    int unsigned strings_sent;
    int unsigned k;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.char_code <= '0;
    in_chan.last_char <= 1'b0;
    hold_req   = 1'b0;
    chars_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      text.delete();
      for (int j = 0; j < directed[i].len(); j++) text.push_back(directed[i][j]);
      send_text($urandom_range(0, 1));
    end
    text = '{8'h00, 8'hFF};
    send_text(1'b0);

    chars_sent   = 0;
    strings_sent = 0;
    while (chars_sent < TEXT_ITEMS) begin
      if (strings_sent == 40) begin
        // receiver backs off while short strings pile up behind it
        hold_req = 1'b1;
        repeat (40) begin
          text.delete();
          put_number();
          put(CH_LC_S);
          send_text(1'b1);
        end
      end
      if (strings_sent == 100) begin
        // hold the input until every word is out
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (open_totals != 0) @(posedge clk);
        repeat (6) @(posedge clk);
      end
      make_text();
      send_text($urandom_range(0, 3) == 0);
      strings_sent++;
    end

    in_chan.valid <= 1'b0;
    @(posedge clk);
    for (k = 0; k < 4000 && open_totals != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (open_totals != 0) $error("%0d words never arrived", open_totals);
    if (fail_count == 0 && open_totals == 0) begin
      $display("duration_text_to_seconds_core_tb OK");
    end else begin
      $display("duration_text_to_seconds_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("duration_text_to_seconds_core_tb NOT OK");
    $finish;
  end

endmodule
